// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/psfa_pkg.sv
package psfa_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_INTEG_LIMIT = 3'd3,
        REG_OUT_LIMIT   = 3'd4,
        REG_DEAD_BAND   = 3'd5
    } reg_index_t;

    // filter weights in q0.16, they sum to one
    localparam logic [31:0] W_NEW = 32'd19661;
    localparam logic [31:0] W_OLD = 32'd45875;

    // rounding offset for q16.16 products
    localparam logic signed [63:0] HALF_Q16_64 = 64'sd32768;
    localparam logic signed [48:0] HALF_Q16_49 = 49'sd32768;

    localparam logic [30:0] DEAD_BAND_RST = 31'd19661;

    // saturate a 33-bit signed value to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // round a q32.32 product to q16.16 and saturate to 32 bits
    function automatic logic signed [31:0] rnd_q16(input logic signed [63:0] p);
        logic signed [63:0] r;
        logic signed [47:0] q;
        logic signed [31:0] s;
        r = p + HALF_Q16_64;
        q = r[63:16];
        if (q[47:31] == {17{q[47]}}) begin
            s = q[31:0];
        end else begin
            s = q[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return s;
    endfunction

endpackage

// File: rtl/psfa_mul.sv
// bit-serial multiplier: signed 32-bit operand times unsigned 32-bit operand,
// one multiplier bit per cycle, 64-bit product after 32 steps
module psfa_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] a,
    input  logic        [31:0] b,
    output logic               done,
    output logic signed [63:0] product
);
    import psfa_pkg::*;

    `include "assert_macros.svh"

    logic signed [32:0] hi_reg;
    logic signed [32:0] hi_next;
    logic        [31:0] lo_reg;
    logic        [31:0] lo_next;
    logic signed [31:0] a_reg;
    logic        [4:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [33:0] part_sum;

    // one shift-add step: add the operand when the low bit is set, shift right
    always_comb begin
        if (lo_reg[0]) begin
            part_sum = {hi_reg[32], hi_reg} + {{2{a_reg[31]}}, a_reg};
        end else begin
            part_sum = {hi_reg[32], hi_reg};
        end
        hi_next = part_sum[33:1];
        lo_next = {part_sum[0], lo_reg[31:1]};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath shift registers
    always_ff @(posedge aclk) begin
        if (start) begin
            hi_reg <= '0;
            lo_reg <= b;
            a_reg  <= a;
        end else if (busy_reg) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg[31:0], lo_reg};

    `ASSERT_SAME(a_no_restart, aclk, aresetn, start, !busy_reg, "multiplier restarted while busy")
    `ASSERT_NEXT(a_done_ends, aclk, aresetn, done_reg, !done_reg && !busy_reg, "done not a single pulse")

endmodule

// File: rtl/pid_step_filtered_antiwindup_unit.sv
// channel   dir  payload (low bits first)          handshake
// s_        in   setpoint[31:0] measured[63:32]    s_tvalid / s_tready
// m_        out  drive[31:0] loop_error[63:32]     m_tvalid / m_tready
// cfg_      in   cfg_index, cfg_wdata              cfg_we, no wait
//
// a step runs five multiplies (start, 32 shift-add steps, done) on the shared
// bit-serial multiplier plus one state each for error, derivative, sum, clamp, drive.
// s_tready is high only while no step is in flight; the result register lets
// a new item in while the previous result waits for m_tready, and a step that
// reaches its drive state holds there until that result register is free.
// reset is synchronous on aresetn and clears the loop state and the gain and limit
// registers; it sets the dead band register to DEAD_BAND_RST.
module pid_step_filtered_antiwindup_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [psfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psfa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,   // setpoint, measured
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata    // drive, loop_error
);
    import psfa_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_FNEW  = 11'b000_0000_0010,
        S_FOLD  = 11'b000_0000_0100,
        S_ERR   = 11'b000_0000_1000,
        S_DER   = 11'b000_0001_0000,
        S_PROP  = 11'b000_0010_0000,
        S_DERIV = 11'b000_0100_0000,
        S_INTEG = 11'b000_1000_0000,
        S_SUM   = 11'b001_0000_0000,
        S_CLAMP = 11'b010_0000_0000,
        S_DRIVE = 11'b100_0000_0000
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [31:0] prop_gain_reg;
    logic [31:0] integ_gain_reg;
    logic [31:0] deriv_gain_reg;
    logic [30:0] integ_limit_reg;
    logic [30:0] out_limit_reg;
    logic [30:0] dead_band_reg;

    // loop state
    logic signed [31:0] prev_sample_reg;
    logic signed [31:0] prev_error_reg;
    logic signed [31:0] accum_reg;

    // step working registers
    logic signed [31:0] setpoint_reg;
    logic signed [31:0] measured_reg;
    logic signed [48:0] filt_sum_reg;
    logic signed [31:0] err_reg;
    logic signed [31:0] der_reg;
    logic signed [31:0] pout_reg;
    logic signed [31:0] dout_reg;
    logic signed [31:0] inc_reg;
    logic signed [33:0] pd_reg;
    logic signed [33:0] test_reg;
    logic signed [31:0] acc_sum_reg;
    logic signed [31:0] acc_new_reg;
    logic               dead_reg;

    // multiplier interface
    logic               mul_start_reg;
    logic signed [31:0] mul_a_reg;
    logic        [31:0] mul_b_reg;
    logic               mul_done;
    logic signed [63:0] mul_product;
    logic signed [31:0] mul_rnd;

    // output register
    logic               m_tvalid_reg;
    logic signed [31:0] drive_reg;
    logic signed [31:0] loop_error_reg;

    // combinational step arithmetic
    logic signed [31:0] filt;
    logic signed [31:0] err_sat;
    logic signed [31:0] der_sat;
    logic signed [33:0] pd_sum;
    logic signed [33:0] test_sum;
    logic signed [31:0] acc_sat;
    logic signed [33:0] olim;
    logic signed [32:0] ilim;
    logic               over_lim;
    logic               under_lim;
    logic               do_integ;
    logic signed [31:0] acc_pick;
    logic signed [31:0] acc_clamp;
    logic        [32:0] err_mag;
    logic               dead_now;
    logic signed [33:0] drv_sum;
    logic signed [31:0] drv_clamp;
    logic               out_free;
    logic               out_load;
    logic               in_xfer;

    psfa_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    assign mul_rnd  = rnd_q16(mul_product);
    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == S_DRIVE) && out_free;

    // error, derivative and the final sums and clamps
    always_comb begin
        filt     = filt_sum_reg[47:16];
        err_sat  = sat33({setpoint_reg[31], setpoint_reg} - {filt[31], filt});
        der_sat  = sat33({err_reg[31], err_reg} - {prev_error_reg[31], prev_error_reg});
        pd_sum   = {{2{pout_reg[31]}}, pout_reg} + {{2{dout_reg[31]}}, dout_reg};
        test_sum = pd_sum + {{2{accum_reg[31]}}, accum_reg};
        acc_sat  = sat33({accum_reg[31], accum_reg} + {inc_reg[31], inc_reg});

        // conditional integration against the output limit
        olim      = $signed({3'b000, out_limit_reg});
        over_lim  = test_reg > olim;
        under_lim = test_reg < -olim;
        if (over_lim) begin
            do_integ = err_reg[31];
        end else if (under_lim) begin
            do_integ = !err_reg[31] && (err_reg != 32'sd0);
        end else begin
            do_integ = 1'b1;
        end
        acc_pick = do_integ ? acc_sum_reg : accum_reg;

        // integral clamp
        ilim = $signed({2'b00, integ_limit_reg});
        if ($signed({acc_pick[31], acc_pick}) > ilim) begin
            acc_clamp = ilim[31:0];
        end else if ($signed({acc_pick[31], acc_pick}) < -ilim) begin
            acc_clamp = 32'(-ilim);
        end else begin
            acc_clamp = acc_pick;
        end

        // deadband on error magnitude
        err_mag  = err_reg[31] ? 33'(-{err_reg[31], err_reg}) : {1'b0, err_reg};
        dead_now = err_mag < {2'b00, dead_band_reg};

        // output clamp
        drv_sum = pd_reg + {{2{acc_new_reg[31]}}, acc_new_reg};
        if (drv_sum > olim) begin
            drv_clamp = olim[31:0];
        end else if (drv_sum < -olim) begin
            drv_clamp = 32'(-olim);
        end else begin
            drv_clamp = drv_sum[31:0];
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            integ_limit_reg <= '0;
            out_limit_reg   <= '0;
            dead_band_reg   <= DEAD_BAND_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata;
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata;
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata;
                REG_INTEG_LIMIT: integ_limit_reg <= cfg_wdata[30:0];
                REG_OUT_LIMIT:   out_limit_reg   <= cfg_wdata[30:0];
                REG_DEAD_BAND:   dead_band_reg   <= cfg_wdata[30:0];
                default: begin
                end
            endcase
        end
    end

    // step sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            mul_start_reg   <= 1'b0;
            prev_sample_reg <= '0;
            prev_error_reg  <= '0;
            accum_reg       <= '0;
        end else begin
            mul_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        mul_a_reg     <= s_tdata[63:32];
                        mul_b_reg     <= W_NEW;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_FNEW;
                    end
                end
                S_FNEW: begin
                    if (mul_done) begin
                        mul_a_reg     <= prev_sample_reg;
                        mul_b_reg     <= W_OLD;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    if (mul_done) begin
                        state_reg <= S_ERR;
                    end
                end
                S_ERR: begin
                    state_reg <= S_DER;
                end
                S_DER: begin
                    mul_a_reg     <= err_reg;
                    mul_b_reg     <= prop_gain_reg;
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_PROP;
                end
                S_PROP: begin
                    if (mul_done) begin
                        mul_a_reg     <= der_reg;
                        mul_b_reg     <= deriv_gain_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_DERIV;
                    end
                end
                S_DERIV: begin
                    if (mul_done) begin
                        mul_a_reg     <= err_reg;
                        mul_b_reg     <= integ_gain_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    if (mul_done) begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    state_reg <= S_CLAMP;
                end
                S_CLAMP: begin
                    state_reg <= S_DRIVE;
                end
                S_DRIVE: begin
                    if (out_free) begin
                        prev_sample_reg <= measured_reg;
                        prev_error_reg  <= err_reg;
                        accum_reg       <= dead_reg ? 32'sd0 : acc_new_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // step datapath registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            setpoint_reg <= s_tdata[31:0];
            measured_reg <= s_tdata[63:32];
        end
        if (state_reg == S_FNEW && mul_done) begin
            filt_sum_reg <= mul_product[48:0];
        end
        if (state_reg == S_FOLD && mul_done) begin
            filt_sum_reg <= filt_sum_reg + mul_product[48:0] + HALF_Q16_49;
        end
        if (state_reg == S_ERR) begin
            err_reg <= err_sat;
        end
        if (state_reg == S_DER) begin
            der_reg <= der_sat;
        end
        if (state_reg == S_PROP && mul_done) begin
            pout_reg <= mul_rnd;
        end
        if (state_reg == S_DERIV && mul_done) begin
            dout_reg <= mul_rnd;
        end
        if (state_reg == S_INTEG && mul_done) begin
            inc_reg <= mul_rnd;
        end
        if (state_reg == S_SUM) begin
            pd_reg      <= pd_sum;
            test_reg    <= test_sum;
            acc_sum_reg <= acc_sat;
        end
        if (state_reg == S_CLAMP) begin
            acc_new_reg <= acc_clamp;
            dead_reg    <= dead_now;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            drive_reg      <= dead_reg ? 32'sd0 : drv_clamp;
            loop_error_reg <= err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {loop_error_reg, drive_reg};

    `ASSERT_SAME(a_done_in_mul_state, aclk, aresetn, mul_done, (state_reg == S_FNEW) || (state_reg == S_FOLD) || (state_reg == S_PROP) || (state_reg == S_DERIV) || (state_reg == S_INTEG), "multiplier done outside a multiply state")
    `ASSERT_NEXT(a_accept_starts, aclk, aresetn, in_xfer, mul_start_reg && !s_tready, "accepted item did not start the filter multiply")
    `ASSERT_NEXT(a_drive_clamped, aclk, aresetn, out_load, ($signed({drive_reg[31], drive_reg}) <= $signed({2'b00, $past(out_limit_reg)})) && ($signed({drive_reg[31], drive_reg}) >= -$signed({2'b00, $past(out_limit_reg)})), "drive beyond output limit")
    `ASSERT_NEXT(a_dead_zero, aclk, aresetn, out_load && dead_reg, (drive_reg == 32'sd0) && (accum_reg == 32'sd0), "deadband did not zero drive and integral")

endmodule

// File: bench/pid_step_filtered_antiwindup_unit_tb.sv
`timescale 1ns / 1ps

module pid_step_filtered_antiwindup_unit_tb;
    import psfa_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 110;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd6;
    localparam logic [31:0] S32_MAX_BITS = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN_BITS = 32'h8000_0000;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    typedef struct {
        logic [31:0] drive;
        logic [31:0] loop_error;
    } step_result_t;

    // controller model: loop state, register copy and pending step results
    class pid_step_tracker;
        logic [31:0] prop_gain, integ_gain, deriv_gain;
        logic [30:0] integ_limit, out_limit, dead_band;
        logic signed [31:0] prev_sample, prev_error, accum;
        step_result_t pending_steps[$];
        int unsigned failures;

        function new();
            prop_gain = '0;
            integ_gain = '0;
            deriv_gain = '0;
            integ_limit = '0;
            out_limit = '0;
            dead_band = DEAD_BAND_RST;
            prev_sample = '0;
            prev_error = '0;
            accum = '0;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_PROP_GAIN:   prop_gain = value;
                REG_INTEG_GAIN:  integ_gain = value;
                REG_DERIV_GAIN:  deriv_gain = value;
                REG_INTEG_LIMIT: integ_limit = value[30:0];
                REG_OUT_LIMIT:   out_limit = value[30:0];
                REG_DEAD_BAND:   dead_band = value[30:0];
                default: ;
            endcase
        endfunction

        function longint clip32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // q16.16 times unsigned q16.16, round half up, saturate
        function longint scale_by(longint x, logic [31:0] gain);
            longint g;
            longint p;
            g = longint'({32'd0, gain});
            p = x * g;
            return clip32((p + 64'sd32768) >>> 16);
        endfunction

        function void note_step(logic signed [31:0] setpoint, logic signed [31:0] measured);
            longint sp, ms, wn, wo, filt, err, der, pd, inc, acc, drv, olim, ilim, mag;
            step_result_t r;
            sp = setpoint;
            ms = measured;
            wn = W_NEW;
            wo = W_OLD;
            olim = out_limit;
            ilim = integ_limit;

            // feedback filter and error terms
            filt = clip32((wn * ms + wo * longint'(prev_sample) + 64'sd32768) >>> 16);
            err = clip32(sp - filt);
            der = clip32(err - longint'(prev_error));
            pd = scale_by(err, prop_gain) + scale_by(der, deriv_gain);

            // conditional integration, then integral clamp
            acc = accum;
            inc = scale_by(err, integ_gain);
            if (pd + acc > olim) begin
                if (err < 0) acc = clip32(acc + inc);
            end else if (pd + acc < -olim) begin
                if (err > 0) acc = clip32(acc + inc);
            end else begin
                acc = clip32(acc + inc);
            end
            if (acc > ilim) acc = ilim;
            else if (acc < -ilim) acc = -ilim;

            // output clamp and deadband
            drv = pd + acc;
            if (drv > olim) drv = olim;
            else if (drv < -olim) drv = -olim;
            mag = (err < 0) ? -err : err;
            if (mag < longint'(dead_band)) begin
                drv = 0;
                acc = 0;
            end

            prev_sample = measured;
            prev_error = err[31:0];
            accum = acc[31:0];
            r.drive = drv[31:0];
            r.loop_error = err[31:0];
            pending_steps.push_back(r);
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10) $display("%0t: %s", $realtime, msg);
        endfunction

        function void check_result(logic [63:0] data);
            step_result_t want;
            if (pending_steps.size() == 0) begin
                note_failure($sformatf("result %h with no step pending", data));
                return;
            end
            want = pending_steps.pop_front();
            if (data[31:0] !== want.drive)
                note_failure($sformatf("drive expected %h actual %h",
                                       want.drive, data[31:0]));
            if (data[63:32] !== want.loop_error)
                note_failure($sformatf("loop_error expected %h actual %h",
                                       want.loop_error, data[63:32]));
        endfunction

        function int pending();
            return pending_steps.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;

    pid_step_tracker tracker;
    int unsigned send_idle_pct = 31;
    int unsigned recv_idle_pct = 49;
    int unsigned quiet_cycles = 0;
    logic [31:0] reg_plan [6];
    logic [31:0] track_sp = '0;

    pid_step_filtered_antiwindup_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side: check each transfer, random backpressure, watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) tracker.check_result(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // one input transfer, with random gaps ahead of it
    task automatic send_step(input logic [31:0] setpoint, input logic [31:0] measured);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < 4) begin
            repeat ($urandom_range(1, 250)) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {measured, setpoint};
        do @(posedge aclk); while (!s_tready);
        tracker.note_step(setpoint, measured);
    endtask

    // stop sending until every pending step has returned
    task automatic drain_steps();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    // write all registers from reg_plan, sometimes an unmapped index too
    task automatic apply_settings();
        for (int i = 0; i < 6; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_wdata <= reg_plan[i];
            tracker.write_reg(i[CFG_IDX_W-1:0], reg_plan[i]);
            @(posedge aclk);
        end
        if ($urandom_range(0, 3) == 0) begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_UNUSED;
            cfg_wdata <= $urandom;
            tracker.write_reg(CFG_IDX_UNUSED, $urandom);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'hffff_ffff;
            2, 3: return $urandom_range(0, 32'h0004_0000);
            4: return ONE_Q16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return S32_MAX_BITS;
            2, 3: return $urandom_range(0, 32'h000a_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_dead_band();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return DEAD_BAND_RST;
            2, 3: return $urandom_range(0, 32'h0002_0000);
            4: return S32_MAX_BITS;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 4))
            0: return S32_MAX_BITS;
            1: return S32_MIN_BITS;
            2: return '0;
            3: return 32'd1;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // mostly a tracked loop near a slowly moving setpoint, then noise and extremes
    task automatic pick_item(output logic [31:0] setpoint, output logic [31:0] measured);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            if ($urandom_range(0, 19) == 0)
                track_sp = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            setpoint = track_sp;
            measured = track_sp + $urandom_range(0, 32'h0002_0000) - ONE_Q16;
        end else if (sel < 80) begin
            setpoint = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            measured = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        end else if (sel < 90) begin
            setpoint = edge_value();
            measured = edge_value();
        end else begin
            setpoint = $urandom;
            measured = $urandom;
        end
    endtask

    initial begin
        logic [31:0] sp, ms;
        int unsigned hold_at;
        tracker = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: zero gains and limits
        send_step(32'd0, 32'd0);
        send_step(S32_MAX_BITS, S32_MIN_BITS);
        send_step(S32_MIN_BITS, S32_MAX_BITS);
        send_step(32'd1, 32'hffff_ffff);
        drain_steps();

        // moderate gains: output saturation, windup guard, deadband edges
        reg_plan[REG_PROP_GAIN] = 32'h0002_0000;
        reg_plan[REG_INTEG_GAIN] = ONE_Q16;
        reg_plan[REG_DERIV_GAIN] = 32'h0000_8000;
        reg_plan[REG_INTEG_LIMIT] = 32'h0003_0000;
        reg_plan[REG_OUT_LIMIT] = 32'h0004_0000;
        reg_plan[REG_DEAD_BAND] = DEAD_BAND_RST;
        apply_settings();
        repeat (4) send_step(32'h000a_0000, 32'd0);
        repeat (3) send_step(32'hfff6_0000, 32'd0);
        send_step(32'd0, 32'd0);
        send_step(DEAD_BAND_RST - 1, 32'd0);
        send_step(DEAD_BAND_RST, 32'd0);
        send_step(-DEAD_BAND_RST, 32'd0);
        drain_steps();

        // full-scale gains and limits: product and error saturation
        reg_plan[REG_PROP_GAIN] = 32'hffff_ffff;
        reg_plan[REG_INTEG_GAIN] = 32'hffff_ffff;
        reg_plan[REG_DERIV_GAIN] = 32'hffff_ffff;
        reg_plan[REG_INTEG_LIMIT] = S32_MAX_BITS;
        reg_plan[REG_OUT_LIMIT] = S32_MAX_BITS;
        reg_plan[REG_DEAD_BAND] = '0;
        apply_settings();
        send_step(S32_MAX_BITS, S32_MIN_BITS);
        send_step(S32_MIN_BITS, S32_MAX_BITS);
        send_step(S32_MAX_BITS, S32_MAX_BITS);
        send_step(S32_MIN_BITS, S32_MIN_BITS);
        send_step(32'd0, S32_MAX_BITS);
        drain_steps();

        // zero limits clamp both integral and output to zero
        reg_plan[REG_PROP_GAIN] = ONE_Q16;
        reg_plan[REG_INTEG_GAIN] = ONE_Q16;
        reg_plan[REG_DERIV_GAIN] = '0;
        reg_plan[REG_INTEG_LIMIT] = '0;
        reg_plan[REG_OUT_LIMIT] = '0;
        reg_plan[REG_DEAD_BAND] = '0;
        apply_settings();
        send_step(ONE_Q16, 32'd0);
        send_step(-ONE_Q16, 32'd0);
        drain_steps();

        // random phases over three idle patterns
        for (int pattern = 0; pattern < 3; pattern++) begin
            send_idle_pct = (pattern == 0) ? 31 : (pattern == 1) ? 49 : 0;
            recv_idle_pct = (pattern == 0) ? 49 : (pattern == 1) ? 31 : 0;
            for (int phase = 0; phase < 3; phase++) begin
                reg_plan[REG_PROP_GAIN] = pick_gain();
                reg_plan[REG_INTEG_GAIN] = pick_gain();
                reg_plan[REG_DERIV_GAIN] = pick_gain();
                reg_plan[REG_INTEG_LIMIT] = pick_limit();
                reg_plan[REG_OUT_LIMIT] = pick_limit();
                reg_plan[REG_DEAD_BAND] = pick_dead_band();
                apply_settings();
                hold_at = $urandom_range(1, ITEMS_PER_PHASE - 1);
                for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                    // hold off the sender once per phase until the pipe is empty
                    if (n == hold_at) drain_steps();
                    pick_item(sp, ms);
                    send_step(sp, ms);
                end
                drain_steps();
            end
        end

        repeat (200) @(posedge aclk);
        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/psfa_pkg.sv
rtl/psfa_mul.sv
rtl/pid_step_filtered_antiwindup_unit.sv
bench/pid_step_filtered_antiwindup_unit_tb.sv
